@@ rtl/core/tpw_pkg.sv @@
// ----------------------------------------------------------------------------
// tpw_pkg
// Shared constants, codes and structures of the tile pixel palette writer.
// ----------------------------------------------------------------------------
package tpw_pkg;

	// Palette storage size; the palette address wraps at this power of two.
	localparam int PALETTE_ENTRIES = 4096;
	localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);

	typedef logic [PAL_AW-1:0] pal_addr_t;

	// Input function codes.
	localparam logic [1:0] FUNC_PAL_WRITE  = 2'd0;
	localparam logic [1:0] FUNC_TILE_START = 2'd1;
	localparam logic [1:0] FUNC_TILE_DATA  = 2'd2;

	// Result kinds.
	localparam logic [1:0] KIND_PIXEL = 2'd0;
	localparam logic [1:0] KIND_FETCH = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_FRAME_BASE = 2'd0;
	localparam logic [1:0] CFG_ROW_PITCH  = 2'd1;
	localparam logic [1:0] CFG_BPP        = 2'd2;

	// Accepted depth codes.
	localparam logic [3:0] DEPTH_2 = 4'h2;
	localparam logic [3:0] DEPTH_4 = 4'h4;
	localparam logic [3:0] DEPTH_8 = 4'h8;

	// Drawing mode of the armed tile.
	typedef enum logic [3:0] {
		MODE_IDLE = 4'b0001,
		MODE_2BIT = 4'b0010,
		MODE_4BIT = 4'b0100,
		MODE_8BIT = 4'b1000
	} mode_t;

	// Configuration register values.
	typedef struct packed {
		logic [31:0] frame_base;
		logic [15:0] row_pitch;
		logic [2:0]  bytes_per_pixel;
	} cfg_t;

	// One result request from the issue stage to the lookup stage.
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] address;
		pal_addr_t   pal_addr;
		logic [2:0]  bpp;
		logic        last;
	} req_t;

	// Palette write port.
	typedef struct packed {
		logic        en;
		pal_addr_t   addr;
		logic [31:0] data;
	} pal_wr_t;

endpackage

@@ rtl/core/tile_pixel_palette_writer.sv @@
// ----------------------------------------------------------------------------
// tile_pixel_palette_writer
// Draws 8x8 tiles of 2, 4 or 8 bits per index into a byte-addressed frame.
// ----------------------------------------------------------------------------
// Usage:
// Configuration beats (cfg_valid/cfg_ready, cfg_index, cfg_data) set the frame
// base, row pitch and frame bytes per pixel; cfg_ready is always high, and the
// registers should only change while no item is in flight.
// Input beats (in_valid/in_ready) carry a palette write, a tile start or a
// tile data byte. A tile start answers with one fetch-address or error beat;
// each data byte answers with one pixel write beat per non-transparent index.
// Output beats (out_valid/out_ready) carry kind, address, color, byte_count
// and last, which marks the final beat caused by one input beat.
// The first result beat of an item passes the input register, the lookup
// stage and the result register. Throughput: one pixel slot per cycle, while
// the lookup stage can take a beat, through the single palette read port; a
// data byte takes one slot per pixel index, a tile start or palette write one.
// A stalled receiver fills the result register and the lookup stage; the input
// register then holds and in_ready drops until beats drain.
// Reset empties all stages, idles the tile state and sets bytes per pixel to 2.
// Palette contents are not cleared and must be written before use.
// ----------------------------------------------------------------------------
module tile_pixel_palette_writer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [11:0] pal_index,
	input  logic [31:0] pal_color,
	input  logic [3:0]  depth_code,
	input  logic [15:0] tile_code,
	input  logic [7:0]  palette_number,
	input  logic [9:0]  pos_x,
	input  logic [9:0]  pos_y,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [31:0] address,
	output logic [31:0] color,
	output logic [2:0]  byte_count,
	output logic        last
);
	import tpw_pkg::*;

	cfg_t    cfg_q;
	logic    req_valid;
	req_t    req;
	logic    req_ready;
	pal_wr_t pal_wr;

	// Configuration registers; writes beyond the list are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_base      <= '0;
			cfg_q.row_pitch       <= '0;
			cfg_q.bytes_per_pixel <= 3'd2;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FRAME_BASE: cfg_q.frame_base      <= cfg_data;
				CFG_ROW_PITCH:  cfg_q.row_pitch       <= cfg_data[15:0];
				CFG_BPP:        cfg_q.bytes_per_pixel <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	tpw_issue u_issue (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.pal_index      (pal_index),
		.pal_color      (pal_color),
		.depth_code     (depth_code),
		.tile_code      (tile_code),
		.palette_number (palette_number),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.data_byte      (data_byte),
		.cfg            (cfg_q),
		.req_valid      (req_valid),
		.req            (req),
		.req_ready      (req_ready),
		.pal_wr         (pal_wr)
	);

	tpw_lookup u_lookup (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req        (req),
		.req_ready  (req_ready),
		.pal_wr     (pal_wr),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.address    (address),
		.color      (color),
		.byte_count (byte_count),
		.last       (last)
	);

endmodule

@@ rtl/core/tpw_issue.sv @@
// ----------------------------------------------------------------------------
// tpw_issue
// Input register and tile drawing state: unpacks one pixel slot per cycle while
// not stalled and issues fetch, error and pixel requests plus palette writes.
// ----------------------------------------------------------------------------
module tpw_issue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       func,
	input  logic [11:0]      pal_index,
	input  logic [31:0]      pal_color,
	input  logic [3:0]       depth_code,
	input  logic [15:0]      tile_code,
	input  logic [7:0]       palette_number,
	input  logic [9:0]       pos_x,
	input  logic [9:0]       pos_y,
	input  logic [7:0]       data_byte,
	input  tpw_pkg::cfg_t    cfg,
	output logic             req_valid,
	output tpw_pkg::req_t    req,
	input  logic             req_ready,
	output tpw_pkg::pal_wr_t pal_wr
);
	import tpw_pkg::*;

	// Input register.
	logic        valid_s1;
	logic [1:0]  func_s1;
	logic [11:0] pal_index_s1;
	logic [31:0] pal_color_s1;
	logic [3:0]  depth_s1;
	logic [15:0] tile_code_s1;
	logic [7:0]  pal_num_s1;
	logic [9:0]  pos_x_s1;
	logic [9:0]  pos_y_s1;
	logic [7:0]  data_s1;

	// Tile drawing state.
	mode_t       mode_q;
	logic [15:0] bank_base_q;
	logic [31:0] row_start_q;
	logic [31:0] pixel_addr_q;
	logic [2:0]  byte_in_row_q;
	logic [2:0]  row_count_q;
	logic [2:0]  bpp_q;
	logic [1:0]  slot_q;

	logic        step;
	logic        item_done;
	logic        is_start;
	logic        is_data;
	logic        depth_ok;
	logic        bpp_ok;
	logic        start_ok;
	mode_t       start_mode;
	logic [25:0] prod_y;
	logic [12:0] prod_x;
	logic [31:0] start_addr;
	logic [31:0] fetch_addr;
	logic [31:0] row_next;
	logic [3:0]  nz;
	logic [3:0]  later_mask;
	logic        later_nz;
	logic        pix_nz;
	logic        last_slot;
	logic        row_end;
	logic [7:0]  shifted;
	logic [7:0]  pix_idx;
	logic [16:0] bank_sum;
	logic [31:0] pal_idx_ext;

	// The item in the input register moves one slot whenever the lookup stage can take a beat.
	assign step      = valid_s1 && req_ready;
	assign is_start  = (func_s1 == FUNC_TILE_START);
	assign is_data   = (func_s1 == FUNC_TILE_DATA) && (mode_q != MODE_IDLE);
	assign item_done = step && (!is_data || last_slot);
	assign in_ready  = !valid_s1 || item_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (item_done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1      <= func;
			pal_index_s1 <= pal_index;
			pal_color_s1 <= pal_color;
			depth_s1     <= depth_code;
			tile_code_s1 <= tile_code;
			pal_num_s1   <= palette_number;
			pos_x_s1     <= pos_x;
			pos_y_s1     <= pos_y;
			data_s1      <= data_byte;
		end
	end

	// Tile start checks, the fetch address and the first row address.
	always_comb begin
		depth_ok = (depth_s1 inside {DEPTH_2, DEPTH_4, DEPTH_8});
		bpp_ok   = (cfg.bytes_per_pixel inside {[3'd2:3'd4]});
		start_ok = depth_ok && bpp_ok;
		case (depth_s1)
			DEPTH_2: start_mode = MODE_2BIT;
			DEPTH_4: start_mode = MODE_4BIT;
			default: start_mode = MODE_8BIT;
		endcase
		prod_y     = pos_y_s1 * cfg.row_pitch;
		prod_x     = pos_x_s1 * cfg.bytes_per_pixel;
		start_addr = cfg.frame_base + {6'd0, prod_y} + {19'd0, prod_x};
		if (depth_s1 == DEPTH_2) begin
			fetch_addr = {11'd0, tile_code_s1, 5'd0};
		end else begin
			fetch_addr = {10'd0, tile_code_s1, 6'd0};
		end
	end

	// Pixel slot unpacking, high bits first.
	always_comb begin
		case (mode_q)
			MODE_2BIT: begin
				nz        = {|data_s1[1:0], |data_s1[3:2], |data_s1[5:4], |data_s1[7:6]};
				shifted   = data_s1 << {slot_q, 1'b0};
				pix_idx   = {6'd0, shifted[7:6]};
				last_slot = (slot_q == 2'd3);
				row_end   = (byte_in_row_q == 3'd1);
			end
			MODE_4BIT: begin
				nz        = {2'b00, |data_s1[3:0], |data_s1[7:4]};
				shifted   = data_s1 << {slot_q[0], 2'b00};
				pix_idx   = {4'd0, shifted[7:4]};
				last_slot = slot_q[0];
				row_end   = (byte_in_row_q == 3'd3);
			end
			MODE_8BIT: begin
				nz        = {3'b000, |data_s1};
				shifted   = data_s1;
				pix_idx   = shifted;
				last_slot = 1'b1;
				row_end   = (byte_in_row_q == 3'd7);
			end
			default: begin
				nz        = 4'b0000;
				shifted   = data_s1;
				pix_idx   = 8'd0;
				last_slot = 1'b1;
				row_end   = 1'b0;
			end
		endcase
		later_mask = 4'b1110 << slot_q;
		later_nz   = |(nz & later_mask);
		pix_nz     = nz[slot_q];
		bank_sum   = {1'b0, bank_base_q} + {9'd0, pix_idx};
		row_next   = row_start_q + {16'd0, cfg.row_pitch};
	end

	// Request toward the lookup stage.
	always_comb begin
		req_valid    = step && (is_start || (is_data && pix_nz));
		req.pal_addr = bank_sum[PAL_AW-1:0];
		if (is_start) begin
			req.kind    = start_ok ? KIND_FETCH : KIND_ERROR;
			req.address = start_ok ? fetch_addr : 32'd0;
			req.bpp     = 3'd0;
			req.last    = 1'b1;
		end else begin
			req.kind    = KIND_PIXEL;
			req.address = pixel_addr_q;
			req.bpp     = bpp_q;
			req.last    = !later_nz;
		end
	end

	// Palette write port.
	assign pal_idx_ext  = {20'd0, pal_index_s1};
	assign pal_wr.en    = step && (func_s1 == FUNC_PAL_WRITE);
	assign pal_wr.addr  = pal_idx_ext[PAL_AW-1:0];
	assign pal_wr.data  = pal_color_s1;

	// Drawing state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_IDLE;
			bank_base_q   <= '0;
			row_start_q   <= '0;
			pixel_addr_q  <= '0;
			byte_in_row_q <= '0;
			row_count_q   <= '0;
			bpp_q         <= 3'd2;
			slot_q        <= '0;
		end else if (step) begin
			if (is_start) begin
				if (start_ok) begin
					mode_q        <= start_mode;
					bank_base_q   <= (depth_s1 == DEPTH_8) ? {pal_num_s1, 8'd0} :
					                                         {4'd0, pal_num_s1, 4'd0};
					bpp_q         <= cfg.bytes_per_pixel;
					row_start_q   <= start_addr;
					pixel_addr_q  <= start_addr;
					byte_in_row_q <= '0;
					row_count_q   <= '0;
					slot_q        <= '0;
				end else begin
					mode_q <= MODE_IDLE;
				end
			end else if (is_data) begin
				if (!last_slot) begin
					slot_q       <= slot_q + 2'd1;
					pixel_addr_q <= pixel_addr_q + {29'd0, bpp_q};
				end else begin
					slot_q <= '0;
					if (row_end) begin
						byte_in_row_q <= '0;
						row_start_q   <= row_next;
						pixel_addr_q  <= row_next;
						if (row_count_q == 3'd7) begin
							row_count_q <= '0;
							mode_q      <= MODE_IDLE;
						end else begin
							row_count_q <= row_count_q + 3'd1;
						end
					end else begin
						byte_in_row_q <= byte_in_row_q + 3'd1;
						pixel_addr_q  <= pixel_addr_q + {29'd0, bpp_q};
					end
				end
			end
		end
	end

	// The slot counter stays within the pixels of one byte of the current mode.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_4BIT) |-> (slot_q <= 2'd1))
		else $error("slot counter past the last 4-bit pixel");
	a_slot_single: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_8BIT || mode_q == MODE_IDLE) |-> (slot_q == 2'd0))
		else $error("slot counter moved without multi-pixel bytes");
	a_row_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_2BIT) |-> (byte_in_row_q <= 3'd1))
		else $error("2-bit row took more than two bytes");

endmodule

@@ rtl/core/tpw_lookup.sv @@
// ----------------------------------------------------------------------------
// tpw_lookup
// Palette memory, lookup stage and result register: reads the palette color
// of each pixel request, trims it to the pixel size and holds the result beat.
// ----------------------------------------------------------------------------
module tpw_lookup (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  tpw_pkg::req_t    req,
	output logic             req_ready,
	input  tpw_pkg::pal_wr_t pal_wr,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       kind,
	output logic [31:0]      address,
	output logic [31:0]      color,
	output logic [2:0]       byte_count,
	output logic             last
);
	import tpw_pkg::*;

	logic [31:0] pal_mem [PALETTE_ENTRIES];

	logic        valid_s2;
	req_t        req_s2;
	logic [31:0] rdata_s2;
	logic        out_free;
	logic [31:0] color_trim;

	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [31:0] address_q;
	logic [31:0] color_q;
	logic [2:0]  byte_count_q;
	logic        last_q;

	assign out_free  = !out_valid_q || out_ready;
	assign req_ready = !valid_s2 || out_free;

	// Palette memory with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (pal_wr.en) begin
			pal_mem[pal_wr.addr] <= pal_wr.data;
		end
		if (req_valid && req_ready) begin
			rdata_s2 <= pal_mem[req.pal_addr];
		end
	end

	// Lookup stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (req_ready) begin
			valid_s2 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s2 <= req;
		end
	end

	// Keep only the low bytes that the frame pixel holds; other beats carry a zero color.
	always_comb begin
		case (req_s2.bpp)
			3'd2:    color_trim = {16'd0, rdata_s2[15:0]};
			3'd3:    color_trim = {8'd0, rdata_s2[23:0]};
			default: color_trim = rdata_s2;
		endcase
		if (req_s2.kind != KIND_PIXEL) begin
			color_trim = 32'd0;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			kind_q       <= req_s2.kind;
			address_q    <= req_s2.address;
			color_q      <= color_trim;
			byte_count_q <= req_s2.bpp;
			last_q       <= req_s2.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign address    = address_q;
	assign color      = color_q;
	assign byte_count = byte_count_q;
	assign last       = last_q;

	// Pixel beats carry a supported pixel size; error beats are empty and final; a stalled beat is held.
	a_pixel_size: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == KIND_PIXEL) |-> (byte_count_q >= 3'd2 && byte_count_q <= 3'd4))
		else $error("pixel beat with unsupported byte count");
	a_error_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == KIND_ERROR) |-> (address_q == 32'd0 && last_q))
		else $error("error beat with address or not final");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q)
		else $error("result beat dropped while the receiver stalled");

endmodule

@@ sim/tile_pixel_palette_writer_tb.sv @@
// ----------------------------------------------------------------------------
// tile_pixel_palette_writer_tb
// Self-checking bench for the tile pixel palette writer. Items go in through
// the input channel with random gaps, and a scoreboard process compares every
// result beat with the beats that a local copy of the drawing logic predicts.
// Directed tests cover reset values, start errors, address wrap, register
// changes inside a tile and short depth runs. Random phases then draw whole
// tiles in every depth, with cut-short tiles and stray items mixed in.
// ----------------------------------------------------------------------------
module tile_pixel_palette_writer_tb;
	import tpw_pkg::*;

	localparam int         TOTAL_ITEMS   = 270;
	localparam int         CALM_ITEMS    = 50;
	localparam int         SETTLE_CYCLES = 8;
	localparam logic [1:0] FUNC_RESERVED = 2'd3;
	localparam logic [1:0] CFG_UNUSED    = 2'd3;

	typedef struct {
		logic [1:0]  func;
		logic [11:0] pal_index;
		logic [31:0] pal_color;
		logic [3:0]  depth_code;
		logic [15:0] tile_code;
		logic [7:0]  palette_number;
		logic [9:0]  pos_x;
		logic [9:0]  pos_y;
		logic [7:0]  data_byte;
	} item_t;

	typedef struct {
		logic [1:0]  kind;
		logic [31:0] address;
		logic [31:0] color;
		logic [2:0]  byte_count;
		logic        last;
	} beat_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  func;
	logic [11:0] pal_index;
	logic [31:0] pal_color;
	logic [3:0]  depth_code;
	logic [15:0] tile_code;
	logic [7:0]  palette_number;
	logic [9:0]  pos_x;
	logic [9:0]  pos_y;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  kind;
	logic [31:0] address;
	logic [31:0] color;
	logic [2:0]  byte_count;
	logic        last;

	// Local copy of the block state, advanced on every accepted beat.
	logic [31:0] pal_mem [PALETTE_ENTRIES];
	bit          pal_loaded [PALETTE_ENTRIES];
	logic [31:0] reg_base  = '0;
	logic [15:0] reg_pitch = '0;
	logic [2:0]  reg_bpp   = 3'd2;
	mode_t       draw_mode = MODE_IDLE;
	pal_addr_t   bank_base = '0;
	logic [31:0] row_addr  = '0;
	logic [31:0] pix_addr  = '0;
	logic [2:0]  row_byte  = '0;
	logic [2:0]  rows_done = '0;
	logic [2:0]  tile_bpp  = 3'd2;

	beat_t       pending_beats [$];
	int          fail_count     = 0;
	int          accepted_items = 0;
	bit          idling_on      = 1'b0;

	tile_pixel_palette_writer DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.pal_index      (pal_index),
		.pal_color      (pal_color),
		.depth_code     (depth_code),
		.tile_code      (tile_code),
		.palette_number (palette_number),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.address        (address),
		.color          (color),
		.byte_count     (byte_count),
		.last           (last)
	);

	always #5 clk = ~clk;

	// Bits per palette index; also the number of data bytes in one tile row.
	function automatic int index_bits(mode_t m);
		case (m)
			MODE_2BIT: return 2;
			MODE_4BIT: return 4;
			default:   return 8;
		endcase
	endfunction

	// Works out the result beats of one accepted item and moves the drawing state on.
	function automatic void draw_item(item_t it);
		beat_t       beats [$];
		beat_t       b;
		int          nbits;
		logic [7:0]  idx;
		pal_addr_t   entry;
		logic [31:0] hue;
		b = '{kind: KIND_PIXEL, address: '0, color: '0, byte_count: '0, last: 1'b0};
		case (it.func)
			FUNC_PAL_WRITE: begin
				pal_mem[it.pal_index]    = it.pal_color;
				pal_loaded[it.pal_index] = 1'b1;
			end
			FUNC_TILE_START: begin
				if ((it.depth_code != DEPTH_2 && it.depth_code != DEPTH_4 &&
						it.depth_code != DEPTH_8) || reg_bpp < 3'd2 || reg_bpp > 3'd4) begin
					draw_mode = MODE_IDLE;
					b.kind    = KIND_ERROR;
				end else begin
					case (it.depth_code)
						DEPTH_2: draw_mode = MODE_2BIT;
						DEPTH_4: draw_mode = MODE_4BIT;
						default: draw_mode = MODE_8BIT;
					endcase
					// Only the low bits of the shifted bank survive the palette wrap.
					if (draw_mode == MODE_8BIT)
						bank_base = pal_addr_t'({it.palette_number, 8'h00});
					else
						bank_base = pal_addr_t'({it.palette_number, 4'h0});
					tile_bpp  = reg_bpp;
					row_addr  = reg_base + 32'(it.pos_y) * 32'(reg_pitch) +
						32'(it.pos_x) * 32'(tile_bpp);
					pix_addr  = row_addr;
					row_byte  = '0;
					rows_done = '0;
					b.kind    = KIND_FETCH;
					b.address = (draw_mode == MODE_2BIT) ? 32'(it.tile_code) << 5 :
						32'(it.tile_code) << 6;
				end
				beats.push_back(b);
			end
			FUNC_TILE_DATA: begin
				if (draw_mode != MODE_IDLE) begin
					nbits = index_bits(draw_mode);
					// Unpack from the high bits; index zero draws nothing.
					for (int p = 0; p < 8 / nbits; p++) begin
						idx = 8'((it.data_byte >> (8 - nbits * (p + 1))) & ((1 << nbits) - 1));
						if (idx != 0) begin
							entry = bank_base + pal_addr_t'(idx);
							hue   = pal_mem[entry];
							if (tile_bpp == 3'd2)
								hue[31:16] = '0;
							else if (tile_bpp == 3'd3)
								hue[31:24] = '0;
							b.address    = pix_addr;
							b.color      = hue;
							b.byte_count = tile_bpp;
							beats.push_back(b);
						end
						pix_addr += 32'(tile_bpp);
					end
					// Row end takes the pitch as it stands now.
					if (32'(row_byte) + 1 >= 32'(nbits)) begin
						row_byte = '0;
						row_addr += 32'(reg_pitch);
						pix_addr = row_addr;
						if (rows_done == 3'd7) begin
							rows_done = '0;
							draw_mode = MODE_IDLE;
						end else begin
							rows_done++;
						end
					end else begin
						row_byte++;
					end
				end
			end
			default: ;
		endcase
		if (beats.size() > 0)
			beats[beats.size() - 1].last = 1'b1;
		foreach (beats[i])
			pending_beats.push_back(beats[i]);
	endfunction

	function automatic item_t random_item(logic [1:0] f);
		item_t it;
		it.func           = f;
		it.pal_index      = 12'($urandom);
		it.pal_color      = $urandom;
		it.depth_code     = 4'($urandom);
		it.tile_code      = 16'($urandom);
		it.palette_number = 8'($urandom);
		it.pos_x          = 10'($urandom);
		it.pos_y          = 10'($urandom);
		it.data_byte      = 8'($urandom);
		return it;
	endfunction

	function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
		if (got_v !== want_v) begin
			fail_count++;
			$error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
		end
	endfunction

	// Sends one input beat, leaving valid high; the caller lowers it or sends on.
	task automatic send_item(input item_t it);
		// The last part of the run goes without idling on either side.
		if (accepted_items >= TOTAL_ITEMS - CALM_ITEMS)
			idling_on = 1'b0;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid       <= 1'b1;
		func           <= it.func;
		pal_index      <= it.pal_index;
		pal_color      <= it.pal_color;
		depth_code     <= it.depth_code;
		tile_code      <= it.tile_code;
		palette_number <= it.palette_number;
		pos_x          <= it.pos_x;
		pos_y          <= it.pos_y;
		data_byte      <= it.data_byte;
		do @(posedge clk); while (!in_ready);
		accepted_items++;
		draw_item(it);
	endtask

	task automatic start_tile(input logic [3:0] depth, input logic [15:0] code,
		input logic [7:0] pal, input logic [9:0] x, input logic [9:0] y);
		item_t it;
		it                = random_item(FUNC_TILE_START);
		it.depth_code     = depth;
		it.tile_code      = code;
		it.palette_number = pal;
		it.pos_x          = x;
		it.pos_y          = y;
		send_item(it);
	endtask

	// Sends one tile data byte, loading first any palette entry that it would read.
	task automatic send_pixels(input logic [7:0] data);
		item_t      it;
		int         nbits;
		logic [7:0] idx;
		pal_addr_t  entry;
		if (draw_mode != MODE_IDLE) begin
			nbits = index_bits(draw_mode);
			for (int p = 0; p < 8 / nbits; p++) begin
				idx   = 8'((data >> (8 - nbits * (p + 1))) & ((1 << nbits) - 1));
				entry = bank_base + pal_addr_t'(idx);
				if (idx != 0 && !pal_loaded[entry]) begin
					it           = random_item(FUNC_PAL_WRITE);
					it.pal_index = entry;
					send_item(it);
				end
			end
		end
		it           = random_item(FUNC_TILE_DATA);
		it.data_byte = data;
		send_item(it);
	endtask

	// Lowers valid, waits for every predicted beat, then lets the pipeline settle.
	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes one register and leaves valid high for a following write.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_FRAME_BASE: reg_base  = data;
			CFG_ROW_PITCH:  reg_pitch = data[15:0];
			CFG_BPP:        reg_bpp   = data[2:0];
			default: ;
		endcase
	endtask

	// Programs all registers once nothing is in flight; unused data bits are random.
	task automatic set_regs(input logic [31:0] base, input logic [15:0] pitch,
		input logic [2:0] bpp);
		wait_quiet();
		write_reg(CFG_FRAME_BASE, base);
		write_reg(CFG_ROW_PITCH, {16'($urandom), pitch});
		write_reg(CFG_BPP, {29'($urandom), bpp});
		if ($urandom_range(0, 3) == 0)
			write_reg(CFG_UNUSED, $urandom);
		cfg_valid <= 1'b0;
	endtask

	// Palette writes at both ends, stray items, and a tile under reset settings.
	task automatic test_reset_state();
		item_t it;
		it           = random_item(FUNC_PAL_WRITE);
		it.pal_index = '0;
		it.pal_color = '0;
		send_item(it);
		it.pal_index = '1;
		it.pal_color = '1;
		send_item(it);
		send_item(random_item(FUNC_TILE_DATA));
		send_item(random_item(FUNC_RESERVED));
		start_tile(DEPTH_4, 16'h0001, 8'h00, 10'd0, 10'd0);
		send_pixels(8'h12);
		send_pixels(8'h00);
	endtask

	// Bad depth codes and bad pixel sizes answer with an error and leave the block idle.
	task automatic test_start_errors();
		start_tile(DEPTH_8, 16'h0002, 8'h01, 10'd3, 10'd4);
		start_tile(4'h0, 16'h0003, 8'h02, 10'd0, 10'd0);
		send_pixels(8'hFF);
		start_tile(4'hF, 16'hFFFF, 8'hFF, 10'h3FF, 10'h3FF);
		set_regs(32'h0, 16'h0, 3'd7);
		start_tile(DEPTH_2, 16'h0004, 8'h00, 10'd1, 10'd1);
		send_pixels(8'h55);
	endtask

	// Addresses wrap past the top of the space; registers change inside a tile.
	task automatic test_address_wrap();
		set_regs(32'hFFFF_FFF0, 16'hFFFF, 3'd4);
		start_tile(DEPTH_8, 16'hFFFF, 8'hFF, 10'h3FF, 10'h3FF);
		send_pixels(8'hFF);
		send_pixels(8'h00);
		send_pixels(8'h01);
		send_pixels(8'h80);
		// The pixel size stays latched; the new pitch applies at the row end.
		set_regs(32'h0000_0100, 16'h0123, 3'd3);
		send_pixels(8'h7F);
		send_pixels(8'hAA);
		send_pixels(8'h55);
		send_pixels(8'h01);
		send_pixels(8'h02);
	endtask

	// Short 2-bit and 4-bit runs, with a new tile started in the middle of one.
	task automatic test_depth_modes();
		set_regs(32'h0001_0000, 16'd640, 3'd2);
		start_tile(DEPTH_2, 16'h8000, 8'h80, 10'd100, 10'd50);
		send_pixels(8'hE4);
		send_pixels(8'h1B);
		start_tile(DEPTH_4, 16'h7FFF, 8'h7F, 10'd1, 10'd2);
		send_pixels(8'hF0);
		send_pixels(8'h0F);
	endtask

	// Random phases of whole tiles, cut-short tiles and stray items.
	task automatic test_random_tiles();
		int          target;
		int          roll;
		int          nbytes;
		logic [31:0] base;
		logic [15:0] pitch;
		logic [2:0]  bpp;
		logic [7:0]  data;
		logic [3:0]  depth;
		logic [9:0]  x;
		logic [9:0]  y;
		item_t       it;
		target = TOTAL_ITEMS;
		while (accepted_items < target) begin
			case ($urandom_range(0, 3))
				0:       base = '0;
				1:       base = '1;
				default: base = $urandom;
			endcase
			case ($urandom_range(0, 3))
				0:       pitch = '0;
				1:       pitch = '1;
				default: pitch = 16'($urandom);
			endcase
			bpp = ($urandom_range(0, 5) == 0) ? 3'($urandom) : 3'($urandom_range(2, 4));
			set_regs(base, pitch, bpp);
			repeat ($urandom_range(2, 4)) begin
				if (accepted_items < target) begin
					roll = $urandom_range(0, 9);
					if (roll < 7) begin
						case ($urandom_range(0, 2))
							0:       depth = DEPTH_2;
							1:       depth = DEPTH_4;
							default: depth = DEPTH_8;
						endcase
						x = ($urandom_range(0, 3) == 0) ? '1 : 10'($urandom);
						y = ($urandom_range(0, 3) == 0) ? '0 : 10'($urandom);
						start_tile(depth, 16'($urandom), 8'($urandom), x, y);
						if (draw_mode != MODE_IDLE) begin
							nbytes = 8 * index_bits(draw_mode);
							// Some tiles are cut short by the next tile start.
							if ($urandom_range(0, 4) == 0)
								nbytes = $urandom_range(1, nbytes - 1);
							repeat (nbytes) begin
								case ($urandom_range(0, 7))
									0:       data = '0;
									1:       data = '1;
									default: data = 8'($urandom);
								endcase
								// The tile in progress is cut off once the item budget is spent.
								if (accepted_items < target)
									send_pixels(data);
							end
						end
					end else if (roll == 7) begin
						send_item(random_item(FUNC_PAL_WRITE));
					end else if (roll == 8) begin
						it = random_item(FUNC_TILE_START);
						send_item(it);
					end else begin
						it = random_item(draw_mode == MODE_IDLE ? FUNC_TILE_DATA : FUNC_RESERVED);
						send_item(it);
					end
				end
			end
		end
	endtask

	// Receiver stalls in random bursts while idling is on.
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (idling_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Each accepted result beat is matched with the oldest prediction.
	always @(posedge clk) begin : score_beats
		beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_beats.size() == 0) begin
				fail_count++;
				$error("result beat with nothing predicted: kind %0d address 0x%0h",
					kind, address);
			end else begin
				want = pending_beats.pop_front();
				check_field("kind", 32'(want.kind), 32'(kind));
				check_field("address", want.address, address);
				check_field("color", want.color, color);
				check_field("byte_count", 32'(want.byte_count), 32'(byte_count));
				check_field("last", 32'(want.last), 32'(last));
			end
		end
	end

	initial begin
		arst_n         <= 1'b0;
		cfg_valid      <= 1'b0;
		cfg_index      <= CFG_FRAME_BASE;
		cfg_data       <= '0;
		in_valid       <= 1'b0;
		func           <= FUNC_PAL_WRITE;
		pal_index      <= '0;
		pal_color      <= '0;
		depth_code     <= '0;
		tile_code      <= '0;
		palette_number <= '0;
		pos_x          <= '0;
		pos_y          <= '0;
		data_byte      <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idling_on = 1'b1;
		test_reset_state();
		test_start_errors();
		test_address_wrap();
		test_depth_modes();
		test_random_tiles();
		wait_quiet();
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/tpw_pkg.sv
rtl/core/tpw_issue.sv
rtl/core/tpw_lookup.sv
rtl/core/tile_pixel_palette_writer.sv
sim/tile_pixel_palette_writer_tb.sv
